>>> rtl/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg: shared definitions for the LRU key/value cache
// Entry count, derived index, rank and count widths, command and CSR constants.
// ----------------------------------------------------------------------------
package lrukv_pkg;

   // number of cache entries (1 to 64)
   localparam int ENTRIES = 16;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CAP_W  = 5;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam int KEY_W  = 32;
   localparam int VAL_W  = 31;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // command codes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

endpackage

>>> rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key/value cache, LRU replacement
// Sequenced engine: one compare/rank unit walks the entries one per cycle.
// ----------------------------------------------------------------------------
// A request word carries a command (get or put), a 32-bit key and a 31-bit
// value. Each request yields exactly one response word: found is set when the
// key was present before the request, and data holds the stored value on a get
// hit and zero otherwise. A get hit or a put hit makes the entry the most
// recent; a put miss fills the lowest free entry while fewer than capacity
// entries are in use, and otherwise replaces the least recent entry. Capacity
// is set through the csr write channel (0 acts as 1, above ENTRIES saturates);
// lowering it does not drop entries, later put misses just evict. The engine
// takes one word at a time and stalls the request side while busy. A lookup
// pass covers one entry per cycle; a hit or a put needs a second rank pass
// over all entries and then a commit step, while a get miss skips both and goes
// from the lookup pass to the result. A finished response sits in an output
// register, so the next request is accepted while it waits to be taken.
module lru_key_value_cache_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic signed [lrukv_pkg::KEY_W-1:0] req_key,
   input  logic [lrukv_pkg::VAL_W-1:0]   req_value,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [lrukv_pkg::VAL_W-1:0]   rsp_data,
   // capacity register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lrukv_pkg::CAP_W-1:0]   csr_data
);
   import lrukv_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,     // lookup pass over all entries
      ST_DECIDE,   // pick the target entry, write key/value
      ST_UPDATE,   // rank pass over all entries
      ST_COMMIT,   // target becomes most recent
      ST_RESULT    // hand the word to the output register
   } state_type;

   // entry storage
   logic [KEY_W-1:0]  key_mem   [ENTRIES];
   logic [VAL_W-1:0]  value_mem [ENTRIES];
   logic [RANK_W-1:0] rank_ff   [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // captured request
   logic             cmd_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;

   // lookup pass results
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0] hit_rank_ff, hit_rank_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              old_ff, old_in;
   logic [IDX_W-1:0]  old_idx_ff, old_idx_in;
   logic [RANK_W-1:0] old_rank_ff, old_rank_in;
   logic [CNT_W-1:0]  used_ff, used_in;

   // update control
   logic [IDX_W-1:0]  tgt_ff, tgt_in;
   logic [RANK_W-1:0] pivot_ff, pivot_in;
   logic              fill_ff, fill_in;
   logic              found_ff, found_in;
   logic [VAL_W-1:0]  data_ff, data_in;

   // output register and capacity
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [VAL_W-1:0]  rsp_data_ff;
   logic [CAP_W-1:0]  cap_ff;

   // storage write strobes
   logic              kv_we;
   logic              key_we;
   logic [IDX_W-1:0]  kv_wa;
   logic              rank_inc;
   logic              commit;

   logic              req_take;
   logic              rsp_load;
   logic [CMP_W-1:0]  cap_eff;
   logic              cur_valid;
   logic [RANK_W-1:0] cur_rank;
   logic              is_put;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_data  = rsp_data_ff;

   assign cur_valid = valid_ff[idx_ff];
   assign cur_rank  = rank_ff[idx_ff];
   assign is_put    = (cmd_ff == CMD_PUT);

   // capacity as used: zero means one, anything above ENTRIES saturates
   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end

   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_in       = old_ff;
      old_idx_in   = old_idx_ff;
      old_rank_in  = old_rank_ff;
      used_in      = used_ff;
      tgt_in       = tgt_ff;
      pivot_in     = pivot_ff;
      fill_in      = fill_ff;
      found_in     = found_ff;
      data_in      = data_ff;
      kv_we        = 1'b0;
      key_we       = 1'b0;
      kv_wa        = tgt_ff;
      rank_inc     = 1'b0;
      commit       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
               idx_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               old_in   = 1'b0;
               used_in  = '0;
            end
         end
         ST_SCAN: begin
            if (cur_valid) begin
               used_in = CNT_W'(used_ff + 1'b1);
               if (key_mem[idx_ff] == key_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = idx_ff;
                  hit_rank_in = cur_rank;
               end
               if (!old_ff || cur_rank > old_rank_ff) begin
                  old_in      = 1'b1;
                  old_idx_in  = idx_ff;
                  old_rank_in = cur_rank;
               end
            end else if (!free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            found_in = hit_ff;
            data_in  = '0;
            idx_in   = '0;
            fill_in  = 1'b0;
            state_in = ST_RESULT;
            priority if (hit_ff) begin
               tgt_in   = hit_idx_ff;
               pivot_in = hit_rank_ff;
               state_in = ST_UPDATE;
               if (is_put) begin
                  kv_we = 1'b1;
                  kv_wa = hit_idx_ff;
               end else begin
                  data_in = value_mem[hit_idx_ff];
               end
            end else if (!is_put) begin
               state_in = ST_RESULT;
            end else if (CMP_W'(used_ff) >= cap_eff || !free_ff) begin
               // evict the least recent entry
               if (old_ff) begin
                  tgt_in   = old_idx_ff;
                  pivot_in = old_rank_ff;
                  kv_we    = 1'b1;
                  key_we   = 1'b1;
                  kv_wa    = old_idx_ff;
                  state_in = ST_UPDATE;
               end
            end else begin
               // fill the lowest free entry, every valid entry ages
               tgt_in   = free_idx_ff;
               fill_in  = 1'b1;
               kv_we    = 1'b1;
               key_we   = 1'b1;
               kv_wa    = free_idx_ff;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            rank_inc = cur_valid &&
                       (fill_ff || (idx_ff != tgt_ff && cur_rank < pivot_ff));
            if (idx_ff == LAST_IDX) begin
               state_in = ST_COMMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            commit   = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load) begin
            rsp_found_ff <= found_ff;
            rsp_data_ff  <= data_ff;
         end
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         if (commit) begin
            valid_ff[tgt_ff] <= 1'b1;
         end
      end
   end

   // recency ranks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (commit) begin
         rank_ff[tgt_ff] <= '0;
      end else if (rank_inc) begin
         rank_ff[idx_ff] <= RANK_W'(cur_rank + 1'b1);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      old_ff      <= old_in;
      old_idx_ff  <= old_idx_in;
      old_rank_ff <= old_rank_in;
      used_ff     <= used_in;
      tgt_ff      <= tgt_in;
      pivot_ff    <= pivot_in;
      fill_ff     <= fill_in;
      found_ff    <= found_in;
      data_ff     <= data_in;
   end

   // key and value storage
   always_ff @(posedge clock) begin
      if (kv_we) begin
         value_mem[kv_wa] <= val_ff;
      end
      if (key_we) begin
         key_mem[kv_wa] <= key_ff;
      end
   end

   // ---- checks ----

   // a response word only appears out of the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside result state");

   // nonzero data is only ever returned for a hit
   a_data_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_found_ff || rsp_data_ff == '0))
      else $error("data returned without a hit");

   // entries are never invalidated once filled
   a_valid_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(valid_ff) >= $past($countones(valid_ff)))
      else $error("valid entry lost");

   // a fill only lands on an entry that was free
   a_fill_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && fill_ff) |-> !valid_ff[tgt_ff])
      else $error("fill targets a valid entry");

endmodule
